FILE: design/lmh_pkg.sv
// Package for the literal match highlighter: sizes, codes and the structs
// passed between the top level and the window cells.
// No dependencies.
package lmh_pkg;

    // Sizes of the pattern window and of the display row space.
    localparam int PATTERN_MAX = 32;
    localparam int MAX_ROWS    = 16;

    // Field widths fixed by the interface.
    localparam int CODE_W   = 16;
    localparam int SET_W    = 8;
    localparam int CHAR_W   = CODE_W + SET_W;
    localparam int PIDX_W   = 5;
    localparam int ROWIN_W  = 4;
    localparam int MASK_W   = 16;
    localparam int CFG_W    = 6;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 2;

    // Derived widths.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Operation codes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    // Register addresses on the configuration port.
    localparam logic [PADDR_W-1:0] ADDR_PATTERN_LENGTH = PADDR_W'(0);

    // One character held in the window.
    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              mark;
        logic [ROW_W-1:0]  row;
    } lmh_slot_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic              shift;
        logic              hit;
        lmh_slot_t         fresh;
        logic [CHAR_W-1:0] pat_char;
    } lmh_bcast_t;

    // Controls selected for one cell.
    typedef struct packed {
        logic append;
        logic load;
        logic in_len;
    } lmh_sel_t;

endpackage

FILE: design/lmh_cell.sv
// One position of the search window: a pattern character, a window character
// with its mark and row, and the comparison between the two.
// Depends on lmh_pkg.
module lmh_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  lmh_pkg::lmh_bcast_t bcast,
    input  lmh_pkg::lmh_sel_t   sel,
    input  lmh_pkg::lmh_slot_t  right_slot,
    output lmh_pkg::lmh_slot_t  left_slot,
    output logic               match
);
    import lmh_pkg::*;

    logic [CHAR_W-1:0] pat_reg;
    logic [CHAR_W-1:0] chr_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              mark_reg;
    lmh_slot_t         slot_next;

    // The slot as seen by the left neighbour, with any match of this cycle marked.
    assign left_slot.chr  = chr_reg;
    assign left_slot.row  = row_reg;
    assign left_slot.mark = mark_reg | (bcast.hit & sel.in_len);

    // Positions beyond the pattern length always agree.
    assign match = ~sel.in_len | (chr_reg == pat_reg);

    // A new character lands here, or the window moves one place towards the exit.
    always_comb begin
        if (sel.append) begin
            slot_next = bcast.fresh;
        end else if (bcast.shift) begin
            slot_next = right_slot;
        end else begin
            slot_next = left_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= 1'b0;
        end else begin
            mark_reg <= slot_next.mark;
        end
    end

    always_ff @(posedge aclk) begin
        chr_reg <= slot_next.chr;
        row_reg <= slot_next.row;
        if (sel.load) begin
            pat_reg <= bcast.pat_char;
        end
    end

endmodule

FILE: design/literal_match_highlighter.sv
// Literal match highlighter: a row of window cells compared in parallel with the pattern.
// Throughput is one text word per cycle unless output back-pressure or a drain holds input;
// the oldest character is shown in the cycle after its pop. A line's first result appears once
// pattern_length words are held (one for length 0). At end of line the remaining window (up to
// PATTERN_MAX words) drains one word a cycle while output is accepted and no input is taken.
// Reset is synchronous, active low; the pattern cells are undefined until loaded.
module literal_match_highlighter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lmh_pkg::PADDR_W-1:0]        paddr,
    input  logic [lmh_pkg::APB_W-1:0]          pwdata,
    output logic [lmh_pkg::APB_W-1:0]          prdata,
    output logic                               pready,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [lmh_pkg::PIDX_W-1:0]         s_pattern_index,
    input  logic [lmh_pkg::CODE_W-1:0]         s_char_code,
    input  logic [lmh_pkg::SET_W-1:0]          s_char_set,
    input  logic [lmh_pkg::ROWIN_W-1:0]        s_row_index,
    input  logic                               s_last_char,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lmh_pkg::CODE_W-1:0]         m_out_code,
    output logic [lmh_pkg::SET_W-1:0]          m_out_set,
    output logic                               m_highlight,
    output logic                               m_end_of_line,
    output logic                               m_line_hit,
    output logic [lmh_pkg::MASK_W-1:0]         m_row_hit_mask
);
    import lmh_pkg::*;

    logic [CFG_W-1:0]  len_cfg_reg;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  overlap_reg, overlap_next;
    logic [MASK_W-1:0] row_hits_reg, row_hits_next;
    logic              any_hit_reg, any_hit_next;
    logic              owed_reg, owed_next;
    logic              flush_reg, flush_next;
    logic              m_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [SET_W-1:0]  out_set_reg;
    logic              highlight_reg, eol_reg, line_hit_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [LEN_W-1:0]  eff_len, win, append_pos;
    logic              pending, pop_need, pop_fire, can_take;
    logic              acc, acc_text, acc_load;
    logic              check_en, all_eq, hit, last_pop;
    logic [MASK_W-1:0] hit_bit;
    logic [ROW_W-1:0]  row_sat;

    lmh_bcast_t                bcast;
    lmh_sel_t                  sel   [PATTERN_MAX];
    lmh_slot_t                 slots [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0]    eq;

    // Configuration register, always ready.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PATTERN_LENGTH) ? {(APB_W-CFG_W)'(0), len_cfg_reg}
                                                   : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_PATTERN_LENGTH) begin
            len_cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Effective length and window size.
    assign eff_len = LEN_W'((int'(len_cfg_reg) > PATTERN_MAX) ? PATTERN_MAX
                                                              : int'(len_cfg_reg));
    assign win     = (eff_len == '0) ? LEN_W'(1) : eff_len;

    // Pops owed to the last text word, or the end-of-line drain.
    assign pending  = owed_reg && (fill_reg >= win);
    assign pop_need = pending || (flush_reg && fill_reg != '0);
    assign pop_fire = pop_need && (!m_valid_reg || m_ready);
    assign can_take = !flush_reg && (!pending || (pop_fire && fill_reg == win));

    assign s_ready  = can_take;
    assign acc      = s_valid && s_ready;
    assign acc_text = acc && (s_operation == OP_TEXT);
    assign acc_load = acc && (s_operation == OP_LOAD);

    // Match decision on the candidate that starts at the oldest character.
    assign all_eq   = &eq;
    assign check_en = pop_fire && (fill_reg >= win) && (eff_len != '0);
    assign hit      = check_en && (overlap_reg == '0) && all_eq;
    assign last_pop = pop_fire && flush_reg && (fill_reg == LEN_W'(1));
    assign hit_bit  = (hit && int'(slots[0].row) < MASK_W)
                      ? (MASK_W'(1) << slots[0].row) : '0;

    assign append_pos = pop_fire ? (fill_reg - LEN_W'(1)) : fill_reg;
    assign row_sat    = ROW_W'((int'(s_row_index) >= MAX_ROWS) ? (MAX_ROWS - 1)
                                                               : int'(s_row_index));

    // Broadcast to the cells.
    assign bcast.shift      = pop_fire;
    assign bcast.hit        = hit;
    assign bcast.fresh.chr  = {s_char_set, s_char_code};
    assign bcast.fresh.mark = 1'b0;
    assign bcast.fresh.row  = row_sat;
    assign bcast.pat_char   = {s_char_set, s_char_code};

    // The chain of window cells; the oldest sits in cell zero.
    assign slots[PATTERN_MAX] = '0;
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        assign sel[i].append = acc_text && (int'(append_pos) == i);
        assign sel[i].load   = acc_load && (int'(s_pattern_index) == i);
        assign sel[i].in_len = (i < int'(eff_len));

        lmh_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .bcast      (bcast),
            .sel        (sel[i]),
            .right_slot (slots[i+1]),
            .left_slot  (slots[i]),
            .match      (eq[i])
        );
    end

    // Next values of the window control and the per-line state.
    always_comb begin
        fill_next = fill_reg - LEN_W'(pop_fire) + LEN_W'(acc_text);
        owed_next = acc_text
                    || (pending && !(pop_fire && (fill_reg - LEN_W'(1)) < win));
        flush_next    = flush_reg;
        overlap_next  = overlap_reg;
        any_hit_next  = any_hit_reg | hit;
        row_hits_next = row_hits_reg | hit_bit;
        if (acc_text && s_last_char) begin
            flush_next = 1'b1;
        end
        if (check_en) begin
            if (hit) begin
                overlap_next = eff_len - LEN_W'(1);
            end else if (overlap_reg != '0) begin
                overlap_next = overlap_reg - LEN_W'(1);
            end
        end
        if (last_pop) begin
            owed_next     = 1'b0;
            flush_next    = 1'b0;
            overlap_next  = '0;
            any_hit_next  = 1'b0;
            row_hits_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            owed_reg     <= 1'b0;
            flush_reg    <= 1'b0;
            overlap_reg  <= '0;
            any_hit_reg  <= 1'b0;
            row_hits_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            owed_reg     <= owed_next;
            flush_reg    <= flush_next;
            overlap_reg  <= overlap_next;
            any_hit_reg  <= any_hit_next;
            row_hits_reg <= row_hits_next;
            if (pop_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register, loaded with the character that leaves the window.
    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            out_code_reg  <= slots[0].chr[CODE_W-1:0];
            out_set_reg   <= slots[0].chr[CHAR_W-1:CODE_W];
            highlight_reg <= slots[0].mark;
            eol_reg       <= last_pop;
            line_hit_reg  <= last_pop && (any_hit_reg || hit);
            mask_reg      <= last_pop ? (row_hits_reg | hit_bit) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_code     = out_code_reg;
    assign m_out_set      = out_set_reg;
    assign m_highlight    = highlight_reg;
    assign m_end_of_line  = eol_reg;
    assign m_line_hit     = line_hit_reg;
    assign m_row_hit_mask = mask_reg;

endmodule
